/* hw/rtl/mwtg_pkg.sv */
// ----------------------------------------------------------------------------
// mwtg_pkg
// shared types, register map, waveform codes and the q2.30 constants
// used to build the sine rom at elaboration
// ----------------------------------------------------------------------------
package mwtg_pkg;

   // register map, index = paddr[3:2]
   localparam int unsigned ADDR_BITS = 4;
   localparam logic [1:0]  REG_PHASE_INC   = 2'd0;
   localparam logic [1:0]  REG_TONE_LENGTH = 2'd1;
   localparam logic [1:0]  REG_WAVEFORM    = 2'd2;

   // field widths fixed by the register and stream layout
   localparam int unsigned INC_BITS    = 32;
   localparam int unsigned LEN_BITS    = 20;
   localparam int unsigned SAMPLE_BITS = 16;
   localparam int unsigned MAG_BITS    = 15;

   // register reset values
   localparam logic [INC_BITS-1:0] PHASE_INC_RESET   = 32'd42852281;
   localparam logic [LEN_BITS-1:0] TONE_LENGTH_RESET = 20'd2205;

   typedef enum logic [1:0] {
      WAVE_SINE    = 2'd0,
      WAVE_SQUARE  = 2'd1,
      WAVE_SAW     = 2'd2,
      WAVE_SILENCE = 2'd3
   } wave_type;

   // amplitudes
   localparam logic [MAG_BITS-1:0]           SQUARE_AMP = 15'd10000;
   localparam logic [MAG_BITS-1:0]           SAW_SPAN   = 15'd28000;
   localparam logic signed [SAMPLE_BITS-1:0] SAW_OFFSET = 16'sd14000;
   localparam longint unsigned               SINE_AMP   = 64'd20000;

   // q2.30 constants for the sine polynomial
   localparam longint unsigned ONE_Q30     = 64'd1 << 30;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

endpackage

/* hw/rtl/multi_waveform_tone_generator.sv */
// ----------------------------------------------------------------------------
// multi_waveform_tone_generator
// dds tone source: one sample tick in, one mono sample out, with sine,
// square, sawtooth and silence waveforms and a linear fade over the tail of a tone
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake            | contents
//  ---------+-----+----------------------+-----------------------------------
//  req_     | in  | tvalid/tready        | tdata[0] restart
//  rsp_     | out | tvalid/tready        | tdata sample, tlast last, tuser active
//  csr_     | in  | psel/penable/pready  | phase_increment, tone_length, waveform
//
//  one tick accepted per clock while rsp_ does not hold req_; its sample is
//  registered through every pipeline stage and the output register, then offered
//  the tone state (phase, index, running) is updated in the accept cycle,
//  so consecutive ticks never wait on each other
//  the sine rom read and the sawtooth partial products share stage 2, while the
//  fade multiply and the reciprocal divide each sit in their own pipeline stage
//  a stall on rsp_ only holds req_ once every stage is full; a bubble in any
//  stage still lets a tick in
//  reset is synchronous and clears state, valids and registers to defaults
//
module multi_waveform_tone_generator #(
   parameter int unsigned PHASE_BITS      = 32,
   parameter int unsigned SINE_TABLE_BITS = 10,
   parameter int unsigned FADE_LEN        = 500,
   parameter int unsigned COUNT_BITS      = 20
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // tick stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,   // [0] restart
   // sample stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [mwtg_pkg::SAMPLE_BITS-1:0]     rsp_tdata,   // [15:0] sample
   output logic                                 rsp_tlast,   // last
   output logic                                 rsp_tuser,   // [0] active
   // register port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [mwtg_pkg::ADDR_BITS-1:0]       csr_paddr,
   input  logic [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);
   import mwtg_pkg::*;

   // derived sizes
   localparam int unsigned QUARTER   = 1 << (SINE_TABLE_BITS - 2);
   localparam int unsigned CMP_BITS  = ((COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS) + 1;
   localparam int unsigned REM_BITS  = $clog2(FADE_LEN + 1);
   localparam int unsigned PROD_BITS = MAG_BITS + REM_BITS;
   localparam int unsigned RCP_BITS  = PROD_BITS + 2;
   localparam int unsigned RCP_SHIFT = PROD_BITS + $clog2(FADE_LEN);
   localparam longint unsigned RCP_VALUE =
      ((64'd1 << RCP_SHIFT) + FADE_LEN - 1) / FADE_LEN;
   localparam logic [RCP_BITS-1:0] FADE_RECIP = RCP_BITS'(RCP_VALUE);
   localparam int unsigned LO_BITS   = PHASE_BITS / 2;
   localparam int unsigned HI_BITS   = PHASE_BITS - LO_BITS;

   // ---------------------------------------------------------------- registers
   logic [INC_BITS-1:0] phase_inc_ff;
   logic [LEN_BITS-1:0] tone_length_ff;
   wave_type            waveform_ff;
   logic                csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_inc_ff   <= PHASE_INC_RESET;
         tone_length_ff <= TONE_LENGTH_RESET;
         waveform_ff    <= WAVE_SINE;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_PHASE_INC:   phase_inc_ff   <= csr_pwdata;
            REG_TONE_LENGTH: tone_length_ff <= csr_pwdata[LEN_BITS-1:0];
            REG_WAVEFORM:    waveform_ff    <= wave_type'(csr_pwdata[1:0]);
            default: ;   // unmapped address, write dropped
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_PHASE_INC:   csr_prdata = phase_inc_ff;
         REG_TONE_LENGTH: csr_prdata = 32'(tone_length_ff);
         REG_WAVEFORM:    csr_prdata = 32'(waveform_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- stall chain
   // each stage loads when it is empty or its contents move on
   logic rsp_valid_ff;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic ld_out, ld5, ld4, ld3, ld2, ld1;
   logic tick;

   assign ld_out     = !rsp_valid_ff || rsp_tready;
   assign ld5        = !s5_valid_ff || ld_out;
   assign ld4        = !s4_valid_ff || ld5;
   assign ld3        = !s3_valid_ff || ld4;
   assign ld2        = !s2_valid_ff || ld3;
   assign ld1        = !s1_valid_ff || ld2;
   assign req_tready = ld1;
   assign tick       = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ld1)    s1_valid_ff  <= req_tvalid;
         if (ld2)    s2_valid_ff  <= s1_valid_ff;
         if (ld3)    s3_valid_ff  <= s2_valid_ff;
         if (ld4)    s4_valid_ff  <= s3_valid_ff;
         if (ld5)    s5_valid_ff  <= s4_valid_ff;
         if (ld_out) rsp_valid_ff <= s5_valid_ff;
      end
   end

   // ---------------------------------------------------------------- tone state
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [COUNT_BITS-1:0] index_ff, index_in;
   logic                  running_ff, running_in;

   logic                  restart;
   logic [PHASE_BITS-1:0] cur_phase;
   logic [COUNT_BITS-1:0] cur_index;
   logic                  cur_run;
   logic [CMP_BITS-1:0]   len_w, idx_w, fade_w, rem_w;
   logic                  is_last, fade_en;
   logic [REM_BITS-1:0]   rem;

   assign restart = req_tdata[0];

   always_comb begin
      // a restart rewinds phase and index before this tick's sample
      cur_phase = restart ? '0 : phase_ff;
      cur_index = restart ? '0 : index_ff;
      cur_run   = restart ? (tone_length_ff != '0) : running_ff;

      len_w  = CMP_BITS'(tone_length_ff);
      idx_w  = CMP_BITS'(cur_index);
      fade_w = CMP_BITS'(FADE_LEN);

      // final sample: length reached, or the index counter is saturated
      is_last = (idx_w + CMP_BITS'(1) >= len_w) || (&cur_index);
      // fade window: the last fade_len-1 samples of a tone at least fade_len long
      fade_en = (len_w >= fade_w) && (idx_w + fade_w > len_w);
      rem_w   = (len_w > idx_w) ? (len_w - idx_w) : '0;
      rem     = rem_w[REM_BITS-1:0];

      if (cur_run) begin
         phase_in   = cur_phase + PHASE_BITS'(phase_inc_ff);
         index_in   = is_last ? cur_index : cur_index + COUNT_BITS'(1);
         running_in = !is_last;
      end else begin
         phase_in   = cur_phase;
         index_in   = cur_index;
         running_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         index_ff   <= '0;
         running_ff <= 1'b0;
      end else if (tick) begin
         phase_ff   <= phase_in;
         index_ff   <= index_in;
         running_ff <= running_in;
      end
   end

   // ---------------------------------------------------------------- stage 1
   // phase and fade control of the accepted tick
   logic [PHASE_BITS-1:0] s1_phase_ff;
   wave_type              s1_wave_ff;
   logic                  s1_fade_ff, s1_active_ff, s1_last_ff;
   logic [REM_BITS-1:0]   s1_rem_ff;

   always_ff @(posedge clock) begin
      if (ld1) begin
         s1_phase_ff  <= cur_phase;
         s1_wave_ff   <= waveform_ff;
         s1_fade_ff   <= fade_en;
         s1_rem_ff    <= rem;
         s1_active_ff <= cur_run;
         s1_last_ff   <= cur_run && is_last;
      end
   end

   // ---------------------------------------------------------------- stage 2
   // sine rom read and sawtooth partial products
   logic [MAG_BITS-1:0] sine_rom [QUARTER+1];

   for (genvar g = 0; g <= QUARTER; g++) begin : g_sine_rom
      // quarter-wave entry in q2.30, nested taylor form
      localparam longint unsigned X  = (longint'(g) * HALF_PI_Q30) >> (SINE_TABLE_BITS - 2);
      localparam longint unsigned X2 = (X * X) >> 30;
      localparam longint unsigned T1 = ONE_Q30 - (((X2 * ONE_Q30) >> 30) / 64'd156);
      localparam longint unsigned T2 = ONE_Q30 - (((X2 * T1) >> 30) / 64'd110);
      localparam longint unsigned T3 = ONE_Q30 - (((X2 * T2) >> 30) / 64'd72);
      localparam longint unsigned T4 = ONE_Q30 - (((X2 * T3) >> 30) / 64'd42);
      localparam longint unsigned T5 = ONE_Q30 - (((X2 * T4) >> 30) / 64'd20);
      localparam longint unsigned T6 = ONE_Q30 - (((X2 * T5) >> 30) / 64'd6);
      localparam longint unsigned S  = (X * T6) >> 30;
      localparam longint unsigned V  = (S * SINE_AMP + (ONE_Q30 >> 1)) >> 30;
      assign sine_rom[g] = MAG_BITS'(V);
   end

   logic [SINE_TABLE_BITS-1:0] sine_k;
   logic [SINE_TABLE_BITS-2:0] sine_idx;
   logic [HI_BITS+MAG_BITS-1:0] saw_hi_in;
   logic [LO_BITS+MAG_BITS-1:0] saw_lo_in;

   always_comb begin
      sine_k = s1_phase_ff[PHASE_BITS-1 -: SINE_TABLE_BITS];
      // odd quadrants run the quarter wave backwards
      if (sine_k[SINE_TABLE_BITS-2])
         sine_idx = (SINE_TABLE_BITS-1)'(QUARTER)
                  - {1'b0, sine_k[SINE_TABLE_BITS-3:0]};
      else
         sine_idx = {1'b0, sine_k[SINE_TABLE_BITS-3:0]};
      saw_hi_in = (HI_BITS+MAG_BITS)'(s1_phase_ff[PHASE_BITS-1:LO_BITS])
                * (HI_BITS+MAG_BITS)'(SAW_SPAN);
      saw_lo_in = (LO_BITS+MAG_BITS)'(s1_phase_ff[LO_BITS-1:0])
                * (LO_BITS+MAG_BITS)'(SAW_SPAN);
   end

   logic [MAG_BITS-1:0]         s2_sine_ff;
   logic                        s2_neg_ff;
   logic [HI_BITS+MAG_BITS-1:0] s2_saw_hi_ff;
   logic [LO_BITS+MAG_BITS-1:0] s2_saw_lo_ff;
   wave_type                    s2_wave_ff;
   logic                        s2_fade_ff, s2_active_ff, s2_last_ff;
   logic [REM_BITS-1:0]         s2_rem_ff;

   always_ff @(posedge clock) begin
      if (ld2) begin
         s2_sine_ff   <= sine_rom[sine_idx];
         s2_neg_ff    <= s1_phase_ff[PHASE_BITS-1];   // second half cycle
         s2_saw_hi_ff <= saw_hi_in;
         s2_saw_lo_ff <= saw_lo_in;
         s2_wave_ff   <= s1_wave_ff;
         s2_fade_ff   <= s1_fade_ff;
         s2_rem_ff    <= s1_rem_ff;
         s2_active_ff <= s1_active_ff;
         s2_last_ff   <= s1_last_ff;
      end
   end

   // ---------------------------------------------------------------- stage 3
   // raw waveform value
   logic [PHASE_BITS+MAG_BITS-1:0]  saw_sum;
   logic [MAG_BITS-1:0]             saw_ramp;
   logic signed [SAMPLE_BITS-1:0]   wave_in;

   always_comb begin
      saw_sum  = {s2_saw_hi_ff, LO_BITS'(0)} + (PHASE_BITS+MAG_BITS)'(s2_saw_lo_ff);
      saw_ramp = saw_sum[PHASE_BITS+MAG_BITS-1:PHASE_BITS];
      unique case (s2_wave_ff)
         WAVE_SINE:
            wave_in = s2_neg_ff ? -$signed({1'b0, s2_sine_ff}) : $signed({1'b0, s2_sine_ff});
         WAVE_SQUARE:
            wave_in = s2_neg_ff ? -$signed({1'b0, SQUARE_AMP}) : $signed({1'b0, SQUARE_AMP});
         WAVE_SAW:
            wave_in = $signed({1'b0, saw_ramp}) - SAW_OFFSET;
         WAVE_SILENCE:
            wave_in = '0;
         default:
            wave_in = '0;
      endcase
   end

   logic signed [SAMPLE_BITS-1:0] s3_wave_ff;
   logic                          s3_fade_ff, s3_active_ff, s3_last_ff;
   logic [REM_BITS-1:0]           s3_rem_ff;

   always_ff @(posedge clock) begin
      if (ld3) begin
         s3_wave_ff   <= wave_in;
         s3_fade_ff   <= s2_fade_ff;
         s3_rem_ff    <= s2_rem_ff;
         s3_active_ff <= s2_active_ff;
         s3_last_ff   <= s2_last_ff;
      end
   end

   // ---------------------------------------------------------------- stage 4
   // magnitude times remaining samples
   logic [SAMPLE_BITS-1:0] abs_wave;
   logic [PROD_BITS-1:0]   fade_prod_in;

   always_comb begin
      abs_wave     = s3_wave_ff[SAMPLE_BITS-1] ? -s3_wave_ff : s3_wave_ff;
      fade_prod_in = PROD_BITS'(abs_wave[MAG_BITS-1:0]) * PROD_BITS'(s3_rem_ff);
   end

   logic [PROD_BITS-1:0]          s4_prod_ff;
   logic signed [SAMPLE_BITS-1:0] s4_wave_ff;
   logic                          s4_fade_ff, s4_active_ff, s4_last_ff;

   always_ff @(posedge clock) begin
      if (ld4) begin
         s4_prod_ff   <= fade_prod_in;
         s4_wave_ff   <= s3_wave_ff;
         s4_fade_ff   <= s3_fade_ff;
         s4_active_ff <= s3_active_ff;
         s4_last_ff   <= s3_last_ff;
      end
   end

   // ---------------------------------------------------------------- stage 5
   // divide by fade_len as a multiply by a rounded-up reciprocal, exact
   // for every product below 2^PROD_BITS
   logic [PROD_BITS+RCP_BITS-1:0] recip_prod;
   logic [MAG_BITS-1:0]           fade_quot_in;

   always_comb begin
      recip_prod   = (PROD_BITS+RCP_BITS)'(s4_prod_ff) * (PROD_BITS+RCP_BITS)'(FADE_RECIP);
      fade_quot_in = MAG_BITS'(recip_prod >> RCP_SHIFT);
   end

   logic [MAG_BITS-1:0]           s5_quot_ff;
   logic signed [SAMPLE_BITS-1:0] s5_wave_ff;
   logic                          s5_fade_ff, s5_active_ff, s5_last_ff;

   always_ff @(posedge clock) begin
      if (ld5) begin
         s5_quot_ff   <= fade_quot_in;
         s5_wave_ff   <= s4_wave_ff;
         s5_fade_ff   <= s4_fade_ff;
         s5_active_ff <= s4_active_ff;
         s5_last_ff   <= s4_last_ff;
      end
   end

   // ---------------------------------------------------------------- output
   logic signed [SAMPLE_BITS-1:0] faded;
   logic [SAMPLE_BITS-1:0]        sample_in;
   logic [SAMPLE_BITS-1:0]        rsp_data_ff;
   logic                          rsp_last_ff, rsp_active_ff;

   always_comb begin
      // fade keeps the sign and truncates the magnitude toward zero
      faded = s5_wave_ff[SAMPLE_BITS-1] ? -$signed({1'b0, s5_quot_ff})
                                        : $signed({1'b0, s5_quot_ff});
      if (!s5_active_ff)
         sample_in = '0;
      else if (s5_fade_ff)
         sample_in = faded;
      else
         sample_in = s5_wave_ff;
   end

   always_ff @(posedge clock) begin
      if (ld_out) begin
         rsp_data_ff   <= sample_in;
         rsp_last_ff   <= s5_last_ff;
         rsp_active_ff <= s5_active_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_active_ff;

   // ---------------------------------------------------------------- checks
   // an idle tick gives silence and never closes a tone
   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> (rsp_tdata == '0) && !rsp_tlast)
      else $error("idle sample not silent");

   // a tone only ends on an accepted tick or a reset
   a_stop_on_tick: assert property (@(posedge clock) disable iff (reset)
      $fell(running_ff) |-> ($past(reset) || $past(tick)))
      else $error("tone stopped without a tick");

   // a restart into a tone longer than one sample leaves it running
   a_restart_runs: assert property (@(posedge clock) disable iff (reset)
      tick && restart && (tone_length_ff > LEN_BITS'(1)) |=> running_ff)
      else $error("restart did not start the tone");

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench for multi_waveform_tone_generator
// drives sample ticks and register writes, predicts every sample, last and
// active flag in step with the tone state, and checks each sample transfer
// against the oldest prediction, with random idling on both streams
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import mwtg_pkg::*;

   // --------------------------------------------------------------- constants
   localparam int unsigned TOTAL_TICKS  = 950;      // stimulus stops about here
   localparam int unsigned CALM_TICKS   = 120;      // final stretch without idling
   localparam int unsigned CYCLE_LIMIT  = 500_000;  // watchdog
   localparam int unsigned SETTLE       = 8;        // pipeline is six deep
   localparam int unsigned DRAIN_CYCLES = 16;

   // tone arithmetic, kept apart from the package
   localparam int              SQUARE_LEVEL  = 10000;
   localparam int              SAW_HALF_SPAN = 14000;
   localparam longint unsigned SAW_FULL_SPAN = 64'd28000;
   localparam longint unsigned SINE_PEAK     = 64'd20000;
   localparam longint unsigned Q30_ONE       = 64'd1 << 30;
   localparam longint unsigned HALF_PI_FIX   = 64'd1686629713;
   localparam int unsigned     FADE_SPAN     = 500;
   localparam int unsigned     INDEX_CEILING = (1 << 20) - 1;
   localparam logic [31:0]     INC_AT_RESET  = 32'd42852281;
   localparam int unsigned     LEN_AT_RESET  = 2205;

   // register slot that the map leaves empty, writes there are dropped
   localparam logic [1:0] REG_SPARE = 2'd3;

   localparam logic [31:0] RESTART = 32'd1;
   localparam logic [31:0] HOLD    = 32'd0;

   // ------------------------------------------------------------------- types
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic                   last;
      logic                   active;
   } tone_out_type;

   typedef enum logic [2:0] {
      OP_TICK,
      OP_SET_INC,
      OP_SET_LEN,
      OP_SET_WAVE,
      OP_SET_SPARE
   } row_op_type;

   typedef struct packed {
      row_op_type   op;
      logic [31:0]  value;   // restart bit for a tick, register data otherwise
      logic         typed;   // expected sample written into the row
      tone_out_type want;
   } stim_row_type;

   typedef enum {
      RUN_SHORT,      // short tones, restarts now and then
      RUN_FADE_TAIL,  // lengths just above the fade span, fade from early on
      RUN_WIDE,       // any length, zero and the maximum among them
      RUN_NOISE       // restarts on half the ticks of a running tone, on average
   } run_kind_type;

   localparam tone_out_type NO_SAMPLE = '0;

   // directed rows: reset state, extremes of the fields and the special cases
   localparam int unsigned N_DIRECTED = 33;
   localparam stim_row_type DIRECTED [N_DIRECTED] = '{
      // idle straight after reset
      '{OP_TICK,      HOLD,                 1'b1, '{16'sd0, 1'b0, 1'b0}},
      '{OP_SET_WAVE,  32'(WAVE_SQUARE),     1'b0, NO_SAMPLE},
      // out of range register index, must not disturb the waveform
      '{OP_SET_SPARE, 32'hFFFF_FFFF,        1'b0, NO_SAMPLE},
      '{OP_TICK,      RESTART,              1'b1, '{16'sd10000, 1'b0, 1'b1}},
      '{OP_TICK,      HOLD,                 1'b0, NO_SAMPLE},
      // one-sample tone, then idle again
      '{OP_SET_LEN,   32'd1,                1'b0, NO_SAMPLE},
      '{OP_TICK,      RESTART,              1'b1, '{16'sd10000, 1'b1, 1'b1}},
      '{OP_TICK,      HOLD,                 1'b1, '{16'sd0, 1'b0, 1'b0}},
      // zero length starts nothing
      '{OP_SET_LEN,   32'd0,                1'b0, NO_SAMPLE},
      '{OP_TICK,      RESTART,              1'b1, '{16'sd0, 1'b0, 1'b0}},
      // largest increment and length, sawtooth from its floor to its top
      '{OP_SET_INC,   32'hFFFF_FFFF,        1'b0, NO_SAMPLE},
      '{OP_SET_LEN,   32'h000F_FFFF,        1'b0, NO_SAMPLE},
      '{OP_SET_WAVE,  32'(WAVE_SAW),        1'b0, NO_SAMPLE},
      '{OP_TICK,      RESTART,              1'b1, '{-16'sd14000, 1'b0, 1'b1}},
      '{OP_TICK,      HOLD,                 1'b0, NO_SAMPLE},
      // silence is still an active sample, restart while running
      '{OP_SET_WAVE,  32'(WAVE_SILENCE),    1'b0, NO_SAMPLE},
      '{OP_TICK,      HOLD,                 1'b1, '{16'sd0, 1'b0, 1'b1}},
      '{OP_TICK,      RESTART,              1'b1, '{16'sd0, 1'b0, 1'b1}},
      // sine at the four quadrant boundaries, peaks and zero crossings
      '{OP_SET_INC,   32'h4000_0000,        1'b0, NO_SAMPLE},
      '{OP_SET_LEN,   32'd4,                1'b0, NO_SAMPLE},
      '{OP_SET_WAVE,  32'(WAVE_SINE),       1'b0, NO_SAMPLE},
      '{OP_TICK,      RESTART,              1'b1, '{16'sd0, 1'b0, 1'b1}},
      '{OP_TICK,      HOLD,                 1'b0, NO_SAMPLE},
      '{OP_TICK,      HOLD,                 1'b0, NO_SAMPLE},
      '{OP_TICK,      HOLD,                 1'b0, NO_SAMPLE},
      // length equal to the fade span fades from the second sample on
      '{OP_SET_INC,   32'd0,                1'b0, NO_SAMPLE},
      '{OP_SET_LEN,   32'd500,              1'b0, NO_SAMPLE},
      '{OP_SET_WAVE,  32'(WAVE_SQUARE),     1'b0, NO_SAMPLE},
      '{OP_TICK,      RESTART,              1'b1, '{16'sd10000, 1'b0, 1'b1}},
      '{OP_TICK,      HOLD,                 1'b0, NO_SAMPLE},
      '{OP_TICK,      HOLD,                 1'b0, NO_SAMPLE},
      // length lowered under the running index, next sample is the last
      '{OP_SET_LEN,   32'd2,                1'b0, NO_SAMPLE},
      '{OP_TICK,      HOLD,                 1'b0, NO_SAMPLE}
   };

   // ------------------------------------------------------------ dut signals
   logic                   clock        = 1'b0;
   logic                   reset        = 1'b1;
   logic                   req_tvalid   = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata    = '0;   // [0] restart
   logic                   rsp_tvalid;
   logic                   rsp_tready   = 1'b0;
   logic [SAMPLE_BITS-1:0] rsp_tdata;           // [15:0] sample
   logic                   rsp_tlast;           // last
   logic                   rsp_tuser;           // [0] active
   logic                   csr_psel     = 1'b0;
   logic                   csr_penable  = 1'b0;
   logic                   csr_pwrite   = 1'b0;
   logic [ADDR_BITS-1:0]   csr_paddr    = '0;
   logic [31:0]            csr_pwdata   = '0;
   logic [31:0]            csr_prdata;
   logic                   csr_pready;

   // ------------------------------------------------------- predictor state
   logic [31:0]  tone_phase   = '0;
   int unsigned  tone_index   = 0;
   bit           tone_running = 1'b0;
   logic [31:0]  cfg_inc      = INC_AT_RESET;
   int unsigned  cfg_len      = LEN_AT_RESET;
   wave_type     cfg_wave     = WAVE_SINE;

   // ---------------------------------------------------------- bookkeeping
   tone_out_type pending_samples [$];   // predictions awaiting their transfer
   int unsigned ticks_sent  = 0;
   int unsigned bad_samples = 0;
   int unsigned cycle_count = 0;
   int unsigned gap_pct     = 25;      // chance of a sender gap before a tick
   int unsigned stall_pct   = 25;      // chance of a receiver stall per cycle
   int unsigned stall_left  = 0;
   bit          calm        = 1'b0;    // no idling on either side

   multi_waveform_tone_generator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // one tick through the tone state: restart, waveform, fade, last flag
   function automatic tone_out_type predict_sample(bit restart);
      tone_out_type    res;
      longint unsigned divisors [6];
      longint unsigned k;
      longint unsigned m;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned s;
      longint unsigned mag;
      longint unsigned rem;
      int              level;
      bit              fin;
      divisors = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
      res = NO_SAMPLE;
      if (restart) begin
         tone_phase   = '0;
         tone_index   = 0;
         tone_running = (cfg_len != 0);
      end
      if (!tone_running) begin
         return res;
      end

      case (cfg_wave)
         WAVE_SINE: begin
            // ten-bit table index: quadrant in the top two bits
            k = 64'(tone_phase >> 22);
            m = k[8] ? 64'd256 - (k & 64'd255) : (k & 64'd255);
            x  = (m * HALF_PI_FIX) >> 8;
            x2 = (x * x) >> 30;
            t  = Q30_ONE;
            for (int i = 0; i < 6; i++) begin
               t = Q30_ONE - (((x2 * t) >> 30) / divisors[i]);
            end
            s = (x * t) >> 30;
            level = int'((s * SINE_PEAK + (Q30_ONE >> 1)) >> 30);
            if (k[9]) begin
               level = -level;
            end
         end
         WAVE_SQUARE: begin
            level = tone_phase[31] ? -SQUARE_LEVEL : SQUARE_LEVEL;
         end
         WAVE_SAW: begin
            level = int'(({32'd0, tone_phase} * SAW_FULL_SPAN) >> 32) - SAW_HALF_SPAN;
         end
         default: begin
            level = 0;
         end
      endcase

      // linear fade over the tail, magnitude truncated toward zero
      if (cfg_len >= FADE_SPAN && tone_index > cfg_len - FADE_SPAN) begin
         rem   = (cfg_len > tone_index) ? 64'(cfg_len - tone_index) : 64'd0;
         mag   = (level < 0) ? 64'(-level) : 64'(level);
         mag   = (mag * rem) / FADE_SPAN;
         level = (level < 0) ? -int'(mag) : int'(mag);
      end

      fin = (64'(tone_index) + 1 >= 64'(cfg_len)) || (tone_index >= INDEX_CEILING);

      res.sample = SAMPLE_BITS'(level);
      res.last   = fin;
      res.active = 1'b1;

      tone_phase = tone_phase + cfg_inc;
      if (fin) begin
         tone_running = 1'b0;
      end else begin
         tone_index = tone_index + 1;
      end
      return res;
   endfunction

   function automatic logic [31:0] pick_increment();
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h4000_0000 >> $urandom_range(0, 10);
         4, 5: return 32'($urandom_range(1, 32'h00FF_FFFF));
         default: return $urandom();
      endcase
   endfunction

   function automatic void note_bad(string what);
      if (bad_samples < 10) begin
         $display("%0t: %s", $realtime, what);
      end
      bad_samples++;
   endfunction

   // one tick transfer; the prediction is queued once the tick is taken
   task automatic push_tick(bit restart, bit typed, tone_out_type want);
      tone_out_type predicted;
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, restart};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = predict_sample(restart);
      pending_samples.insert(pending_samples.size(), typed ? want : predicted);
      ticks_sent++;
   endtask

   // register write, only once every sample in flight has come out
   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      req_tvalid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_PHASE_INC:   cfg_inc  = value;
         REG_TONE_LENGTH: cfg_len  = int'(value[LEN_BITS-1:0]);
         REG_WAVEFORM:    cfg_wave = wave_type'(value[1:0]);
         default: ;
      endcase
   endtask

   // receiver back-pressure in bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
         stall_left = $urandom_range(1, 12);
      end
      rsp_tready <= (stall_left == 0);
   end

   // sample checker: every transfer against the oldest prediction
   always @(posedge clock) begin : check_samples
      tone_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_samples.size() == 0) begin
            note_bad($sformatf("sample %0d last %b active %b with none expected",
                               $signed(rsp_tdata), rsp_tlast, rsp_tuser));
         end else begin
            want = pending_samples.pop_front();
            if (rsp_tdata !== want.sample || rsp_tlast !== want.last ||
                rsp_tuser !== want.active) begin
               note_bad($sformatf("sample exp %0d got %0d, last exp %b got %b, active exp %b got %b",
                                  $signed(want.sample), $signed(rsp_tdata), want.last,
                                  rsp_tlast, want.active, rsp_tuser));
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ----------------------------------------------------------------- stimulus
   initial begin
      run_kind_type kind;
      int unsigned  n;
      int unsigned  odds;
      bit           rs;
      bit           fade_done;
      fade_done = 1'b0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed rows
      for (int i = 0; i < N_DIRECTED; i++) begin
         case (DIRECTED[i].op)
            OP_TICK:     push_tick(DIRECTED[i].value[0], DIRECTED[i].typed,
                                   DIRECTED[i].want);
            OP_SET_INC:  write_reg(REG_PHASE_INC, DIRECTED[i].value);
            OP_SET_LEN:  write_reg(REG_TONE_LENGTH, DIRECTED[i].value);
            OP_SET_WAVE: write_reg(REG_WAVEFORM, DIRECTED[i].value);
            default:     write_reg(REG_SPARE, DIRECTED[i].value);
         endcase
      end

      // random runs, each under one register setting
      while (ticks_sent < TOTAL_TICKS) begin
         calm = (ticks_sent + CALM_TICKS >= TOTAL_TICKS);
         // idling per run: none, light or heavy
         case ($urandom_range(0, 2))
            0: gap_pct = 0;
            1: gap_pct = 10;
            default: gap_pct = 40;
         endcase
         case ($urandom_range(0, 2))
            0: stall_pct = 0;
            1: stall_pct = 8;
            default: stall_pct = 30;
         endcase

         if (!fade_done && ticks_sent >= 150) begin
            // a run long enough to take one whole tone through its fade, down to the last sample
            fade_done = 1'b1;
            write_reg(REG_PHASE_INC, pick_increment());
            write_reg(REG_WAVEFORM, 32'($urandom_range(0, 2)));
            write_reg(REG_TONE_LENGTH, 32'(FADE_SPAN + $urandom_range(0, 12)));
            n    = cfg_len + $urandom_range(2, 8);
            odds = 0;
         end else begin
            kind = run_kind_type'($urandom_range(0, 3));
            if ($urandom_range(0, 3) != 0) write_reg(REG_PHASE_INC, pick_increment());
            if ($urandom_range(0, 3) != 0) write_reg(REG_WAVEFORM, 32'($urandom_range(0, 3)));
            case (kind)
               RUN_SHORT: begin
                  write_reg(REG_TONE_LENGTH, 32'($urandom_range(1, 48)));
                  n    = $urandom_range(40, 90);
                  odds = 10;
               end
               RUN_FADE_TAIL: begin
                  write_reg(REG_TONE_LENGTH, 32'(FADE_SPAN + $urandom_range(0, 60)));
                  n    = $urandom_range(30, 90);
                  odds = 0;
               end
               RUN_WIDE: begin
                  case ($urandom_range(0, 3))
                     0: write_reg(REG_TONE_LENGTH, 32'd0);
                     1: write_reg(REG_TONE_LENGTH, 32'h000F_FFFF);
                     2: write_reg(REG_TONE_LENGTH, 32'($urandom_range(1, 499)));
                     default: write_reg(REG_TONE_LENGTH, 32'($urandom_range(0, 20'hF_FFFF)));
                  endcase
                  n    = $urandom_range(20, 60);
                  odds = 30;
               end
               default: begin
                  write_reg(REG_TONE_LENGTH, 32'($urandom_range(0, 100)));
                  n    = $urandom_range(10, 40);
                  odds = 1;
               end
            endcase
         end

         for (int i = 0; i < n; i++) begin
            if (i == 0) begin
               // sometimes carry the previous tone over into the new setting
               rs = ($urandom_range(0, 4) != 0);
            end else if (!tone_running) begin
               rs = ($urandom_range(0, 2) == 0);
            end else begin
               rs = (odds != 0) && ($urandom_range(0, odds) == 0);
            end
            push_tick(rs, 1'b0, NO_SAMPLE);
         end
      end

      // drain, then give the pipeline time to show any stray sample
      calm = 1'b1;
      req_tvalid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      bad_samples += pending_samples.size();
      if (bad_samples == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
